FILE: hdl/raised_cosine_tremolo_assert.svh
// Assertion macros for the raised-cosine tremolo block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef RAISED_COSINE_TREMOLO_ASSERT_SVH
`define RAISED_COSINE_TREMOLO_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled during reset.
`define RCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

FILE: hdl/rct_pkg.sv
// Shared types, constants and the cosine table function for the tremolo block.
// No dependencies.
package rct_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH      = 2'd2;

    localparam int PHASE_STEP_W = 31;
    localparam int DEPTH_W      = 16;
    localparam int COS_W        = 16;
    localparam int ONE_MINUS_W  = 17;
    localparam int GAIN_W       = 32;
    localparam int MUL_W        = 32;

    localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 31'd357914;
    localparam logic [DEPTH_W-1:0]      DEPTH_RESET      = 16'd19661;
    localparam logic [DEPTH_W-1:0]      DEPTH_FULL       = 16'd32768;
    localparam logic [ONE_MINUS_W-1:0]  COS_ONE          = 17'd32768;
    localparam logic [GAIN_W-1:0]       GAIN_ONE         = 32'h8000_0000;
    localparam logic [63:0]             ROUND_HALF       = 64'h0000_0000_4000_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_GAIN,
        ST_MUL,
        ST_FIN
    } rct_state_t;

    // cos(x) for x in Q30 radians, nine Taylor terms with truncating steps,
    // clamped to 0..1 and rounded half up to Q15.
    function automatic logic [COS_W-1:0] cos_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [65:0] sum;
        logic [63:0]        rnd;
        x2  = (x * x) >> 30;
        mag = ONE_Q30;
        sum = $signed({2'b00, ONE_Q30});
        mag = ((mag * x2) >> 30) / 2;
        sum = sum - $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 12;
        sum = sum + $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 30;
        sum = sum - $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 56;
        sum = sum + $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 90;
        sum = sum - $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 132;
        sum = sum + $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 182;
        sum = sum - $signed({2'b00, mag});
        mag = ((mag * x2) >> 30) / 240;
        sum = sum + $signed({2'b00, mag});
        if (sum < 66'sd0)
            sum = 66'sd0;
        if (sum > $signed({2'b00, ONE_Q30}))
            sum = $signed({2'b00, ONE_Q30});
        rnd = (64'(sum) + 64'd16384) >> 15;
        return COS_W'(rnd);
    endfunction

endpackage

FILE: hdl/rct_if.sv
// Channel interfaces for the tremolo block: sample in, sample out, config write.
// Depends on rct_pkg for the config field widths.
interface rct_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           frame_last;

    modport source (output valid, sample_in, frame_last, input ready);
    modport sink   (input valid, sample_in, frame_last, output ready);
endinterface

interface rct_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

interface rct_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rct_pkg::CFG_INDEX_W-1:0]  index;
    logic [rct_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/raised_cosine_tremolo.sv
// Raised-cosine tremolo: per-frame LFO gain applied to each sample.
// Enabled: table lookup, gain and multiply states, then the output register.
// Disabled: straight to the output register. Busy until each sample is stored there;
// the shared 32x32 multiplier is used once for the gain and once for the sample.
// Reset: config registers to defaults, LFO phase 0, output empty; the cosine
// table is constant and needs no fill.
`include "raised_cosine_tremolo_assert.svh"

module raised_cosine_tremolo #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int PHASE_WIDTH     = 32,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    rct_cfg_if.sink  cfg,
    rct_in_if.sink   din,
    rct_out_if.source dout
);
    import rct_pkg::*;

    localparam int QUAD_BITS  = PHASE_WIDTH - 2;
    localparam int ADDR_W     = $clog2(COS_TABLE_DEPTH + 1);
    localparam int IDX_PROD_W = QUAD_BITS + ADDR_W;

    // Configuration registers
    logic                    enable_reg;
    logic [PHASE_STEP_W-1:0] phase_step_reg;
    logic [DEPTH_W-1:0]      depth_reg;

    // Control state
    rct_state_t             state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;

    // Datapath
    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic                    last_reg, last_next;
    logic                    neg_cos_reg, neg_cos_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [SAMPLE_WIDTH-1:0] res_reg, res_next;
    logic [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    logic                    din_ready;
    logic [PHASE_WIDTH-1:0]  phase_inc;
    logic [1:0]              quad;
    logic [QUAD_BITS-1:0]    frac;
    logic [IDX_PROD_W-1:0]   idx_prod;
    logic [ADDR_W-1:0]       idx;
    logic [ADDR_W-1:0]       rom_addr;
    logic [COS_W-1:0]        rom_data;
    logic [ONE_MINUS_W-1:0]  one_minus;
    logic [DEPTH_W-1:0]      depth_eff;
    logic [SAMPLE_WIDTH:0]   smp_ext;
    logic [SAMPLE_WIDTH:0]   mag;
    logic                    smp_neg;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      mul_p;
    logic [2*MUL_W-1:0]      rnd_sum;
    logic [MUL_W-1:0]        rounded;
    logic [SAMPLE_WIDTH-1:0] result;

    // Config write port: always ready, unknown indexes dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            phase_step_reg <= PHASE_STEP_RESET;
            depth_reg      <= DEPTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ENABLE:     enable_reg     <= cfg.data[0];
                REG_PHASE_STEP: phase_step_reg <= cfg.data[PHASE_STEP_W-1:0];
                REG_DEPTH:      depth_reg      <= cfg.data[DEPTH_W-1:0];
                default:        ;
            endcase
        end
    end

    // Scale the 32-bit-referenced step to the accumulator width
    if (PHASE_WIDTH >= 32)
    begin : g_inc_wide
        assign phase_inc = PHASE_WIDTH'(phase_step_reg) << (PHASE_WIDTH - 32);
    end
    else
    begin : g_inc_narrow
        assign phase_inc = PHASE_WIDTH'(phase_step_reg >> (32 - PHASE_WIDTH));
    end

    // Table address: mirror the index in odd quadrants
    assign quad     = phase_reg[PHASE_WIDTH-1:PHASE_WIDTH-2];
    assign frac     = phase_reg[QUAD_BITS-1:0];
    assign idx_prod = IDX_PROD_W'(frac) * IDX_PROD_W'(COS_TABLE_DEPTH);
    assign idx      = idx_prod[IDX_PROD_W-1:QUAD_BITS];
    assign rom_addr = quad[0] ? (ADDR_W'(COS_TABLE_DEPTH) - idx) : idx;

    rct_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign one_minus = neg_cos_reg ? (COS_ONE + ONE_MINUS_W'(rom_data))
                                   : (COS_ONE - ONE_MINUS_W'(rom_data));
    assign depth_eff = (depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg;

    // Sign-magnitude split; the most negative sample maps to 2^(W-1)
    assign smp_neg = sample_reg[SAMPLE_WIDTH-1];
    assign smp_ext = {sample_reg[SAMPLE_WIDTH-1], sample_reg};
    assign mag     = smp_neg ? (~smp_ext + 1'b1) : smp_ext;

    // Shared multiplier
    assign mul_p   = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    assign rnd_sum = mul_p + ROUND_HALF;
    assign rounded = rnd_sum[2*MUL_W-2:MUL_W-1];
    assign result  = smp_neg ? SAMPLE_WIDTH'(~rounded + 1'b1) : SAMPLE_WIDTH'(rounded);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        neg_cos_reg  <= neg_cos_next;
        gain_reg     <= gain_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        neg_cos_next   = neg_cos_reg;
        gain_next      = gain_reg;
        res_next       = res_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_data_next  = out_data_reg;
        din_ready      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                din_ready = 1'b1;
                if (din.valid)
                begin
                    sample_next = din.sample_in;
                    last_next   = din.frame_last;
                    res_next    = din.sample_in;
                    state_next  = enable_reg ? ST_LOOK : ST_FIN;
                end
            end
            ST_LOOK:
            begin
                // table read lands in the next cycle
                neg_cos_next = quad[0] ^ quad[1];
                state_next   = ST_GAIN;
            end
            ST_GAIN:
            begin
                mul_a      = MUL_W'(depth_eff);
                mul_b      = MUL_W'(one_minus);
                gain_next  = GAIN_ONE - mul_p[GAIN_W-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_a    = MUL_W'(mag);
                mul_b    = gain_reg;
                res_next = result;
                if (last_reg)
                    phase_next = phase_reg + phase_inc;
                if (!out_valid_reg || dout.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || dout.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign din.ready       = din_ready;
    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;

    `RCT_ASSERT_NEXT(a_phase_moves_only_in_mul, (state_reg != ST_MUL), $stable(phase_reg))
    `RCT_ASSERT_IMPL(a_gain_in_range, (state_reg == ST_MUL), (gain_reg <= GAIN_ONE))
    `RCT_ASSERT_NEXT(a_busy_after_accept, (din.valid && din.ready), !din.ready)
    `RCT_ASSERT_NEXT(a_park_on_stall, (state_reg == ST_MUL && dout.valid && !dout.ready),
        (state_reg == ST_FIN))

endmodule

FILE: hdl/rct_cos_rom.sv
// Quarter-wave cosine table, DEPTH+1 entries in Q1.15, with a registered read.
// Depends on rct_pkg for the table function.
module rct_cos_rom #(
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic [$clog2(DEPTH+1)-1:0]    addr,
    output logic [rct_pkg::COS_W-1:0]     data
);
    import rct_pkg::*;

    logic [COS_W-1:0] rom [DEPTH+1];

    for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
        assign rom[k] = cos_q15((HALF_PI_Q30 * 64'(k)) / DEPTH);
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule
